### hw/rtl/emb_pkg.sv
package emb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int GEOM_W     = COL_W + 1;
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int GAIN_W     = 12;
    localparam int OFFSET_W   = 10;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = 11;
    localparam int PROD_W     = GAIN_W + SUM_W;
    localparam int WIN_N      = 9;

    localparam int CMD_DEPTH  = 4;
    localparam int OUT_DEPTH  = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(3);

    localparam int GAIN_RESET   = 256;
    localparam int OFFSET_RESET = 128;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int MIN_DIM      = 3;

    typedef struct packed {
        logic [GEOM_W-1:0] w;
        logic [COL_W-1:0]  wm1;
        logic [ROW_W-1:0]  h;
        logic [ROW_W-1:0]  hm1;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             do_out;
        logic             edge_sel;
        logic             border;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } out_t;

    function automatic logic [GEOM_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [GEOM_W-1:0] r;
        if (int'(v) < MIN_DIM) begin
            r = GEOM_W'(MIN_DIM);
        end else if (int'(v) > MAX_WIDTH) begin
            r = GEOM_W'(MAX_WIDTH);
        end else begin
            r = GEOM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (int'(v) < MIN_DIM) begin
            r = ROW_W'(MIN_DIM);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = ROW_W'(MAX_HEIGHT);
        end else begin
            r = ROW_W'(v);
        end
        return r;
    endfunction

endpackage

### hw/rtl/emb_ram.sv
module emb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on an address collision
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/emb_front.sv
module emb_front
    import emb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] in_pixel,
    input  logic             in_start,
    input  logic             in_flush,
    input  geom_t            geom,
    input  logic             q_full,
    output logic             push,
    output cmd_t             push_cmd
);

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic              accept;
    logic [COL_W-1:0]  ic0, ic1, ic2, oc0, oc1, oc2;
    logic [ROW_W-1:0]  ir0, ir1, ir2, or0, or1, or2;
    logic [GEOM_W-1:0] ic_inc, oc_inc;
    logic              finished, surplus, live, do_out, edge_sel;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        ic0 = in_start ? '0 : in_col_reg;
        ir0 = in_start ? '0 : in_row_reg;
        oc0 = in_start ? '0 : out_col_reg;
        or0 = in_start ? '0 : out_row_reg;

        // geometry may have shrunk under the counters
        if ({1'b0, ic0} >= geom.w) begin
            ic1 = '0;
            ir1 = ir0 + ROW_W'(1);
        end else begin
            ic1 = ic0;
            ir1 = ir0;
        end
        if ({1'b0, oc0} >= geom.w) begin
            oc1 = '0;
            or1 = or0 + ROW_W'(1);
        end else begin
            oc1 = oc0;
            or1 = or0;
        end

        finished = or1 >= geom.h;
        surplus  = ir1 >= geom.h;
        live     = !finished && (surplus || !in_flush);
        do_out   = !((ir1 == '0) || ((ir1 == ROW_W'(1)) && (ic1 == '0)));

        ic_inc = {1'b0, ic1} + GEOM_W'(1);
        if (ic_inc >= geom.w) begin
            ic2 = '0;
            ir2 = ir1 + ROW_W'(1);
        end else begin
            ic2 = ic_inc[COL_W-1:0];
            ir2 = ir1;
        end
        oc_inc = {1'b0, oc1} + GEOM_W'(1);
        if (oc_inc >= geom.w) begin
            oc2 = '0;
            or2 = or1 + ROW_W'(1);
        end else begin
            oc2 = oc_inc[COL_W-1:0];
            or2 = or1;
        end

        edge_sel = oc1 == geom.wm1;

        push_cmd.pix      = surplus ? '0 : in_pixel;
        push_cmd.col      = ic1;
        push_cmd.do_out   = do_out;
        push_cmd.edge_sel = edge_sel;
        push_cmd.border   = (or1 == '0) || (or1 == geom.hm1) || (oc1 == '0) || edge_sel;
        push_cmd.last     = (or1 == geom.hm1) && edge_sel;
        push              = accept && live;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept) begin
            in_col_next  = live ? ic2 : ic1;
            in_row_next  = live ? ir2 : ir1;
            out_col_next = (live && do_out) ? oc2 : oc1;
            out_row_next = (live && do_out) ? or2 : or1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

### hw/rtl/emb_cmd_queue.sv
module emb_cmd_queue
    import emb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(CMD_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/emb_back.sv
module emb_back
    import emb_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  cmd_t                       head_cmd,
    output logic                       pop,
    input  geom_t                      geom,
    input  logic signed [GAIN_W-1:0]   gain,
    input  logic signed [OFFSET_W-1:0] offset,
    output logic                       out_valid,
    input  logic                       out_ready,
    output out_t                       out_item
);

    localparam int OPTR_W   = $clog2(OUT_DEPTH);
    localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);
    localparam int CREDIT_W = OCNT_W + 1;
    localparam int T_W      = PROD_W + 1;

    // line stores; the edge copy mirrors the two-rows-up store for the last column read
    logic [PIX_W-1:0] l1_rd, l2_rd, edge_rd;
    logic             wr_en;

    // line-store read stage
    logic             s2_valid_reg;
    cmd_t             s2_cmd_reg;
    // last write, forwarded to the read that follows it into the read stage in the next cycle
    logic             wr_valid_reg;
    logic [COL_W-1:0] wr_addr_reg;
    logic [PIX_W-1:0] wr_pix_reg;
    logic [PIX_W-1:0] wr_b_reg;

    logic [PIX_W-1:0] win_reg [WIN_N];
    logic [PIX_W-1:0] a_pix, b_pix, rot_pix;
    logic             fwd_col, fwd_edge;

    // kernel sum stage
    logic             s3_valid_reg;
    cmd_t             s3_cmd_reg;
    logic [PIX_W-1:0] s3_rot_reg;
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0] own;

    // multiply stage
    logic             s4_valid_reg;
    cmd_t             s4_cmd_reg;
    logic signed [SUM_W-1:0] s4_sum_reg;
    logic [PIX_W-1:0] s4_own_reg;
    logic signed [PROD_W-1:0] gain_x, sum_x;

    // bias and clamp stage
    logic             s5_valid_reg;
    cmd_t             s5_cmd_reg;
    logic signed [PROD_W-1:0] s5_prod_reg;
    logic [PIX_W-1:0] s5_own_reg;
    logic signed [T_W-1:0] t_full;
    logic [PIX_W-1:0] emb_pix;
    out_t             res;
    logic             res_push;

    // result queue
    out_t              omem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] owr_ptr_reg, ord_ptr_reg;
    logic [OCNT_W-1:0] ocount_reg, ocount_next;
    logic [OCNT_W-1:0] inflight;
    logic              out_pop;

    // issue only when every item in flight is sure of a result slot
    assign inflight = OCNT_W'($countones({s2_valid_reg, s3_valid_reg,
                                          s4_valid_reg, s5_valid_reg}));
    assign pop = head_valid &&
                 ((CREDIT_W'(ocount_reg) + CREDIT_W'(inflight)) < CREDIT_W'(OUT_DEPTH));

    emb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_cmd_reg.col),
        .wr_data (s2_cmd_reg.pix),
        .rd_addr (head_cmd.col),
        .rd_data (l1_rd)
    );

    emb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_cmd_reg.col),
        .wr_data (b_pix),
        .rd_addr (head_cmd.col),
        .rd_data (l2_rd)
    );

    emb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_edge_copy (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s2_cmd_reg.col),
        .wr_data (b_pix),
        .rd_addr (geom.wm1),
        .rd_data (edge_rd)
    );

    always_comb begin
        wr_en    = s2_valid_reg;
        fwd_col  = wr_valid_reg && (wr_addr_reg == s2_cmd_reg.col);
        fwd_edge = wr_valid_reg && (wr_addr_reg == geom.wm1);
        b_pix    = fwd_col ? wr_pix_reg : l1_rd;
        a_pix    = fwd_col ? wr_b_reg : l2_rd;
        rot_pix  = fwd_edge ? wr_b_reg : edge_rd;
    end

    always_comb begin
        sum = SUM_W'(win_reg[5]) + SUM_W'(win_reg[7]) + SUM_W'(win_reg[8])
            - SUM_W'(win_reg[0]) - SUM_W'(win_reg[1]) - SUM_W'(win_reg[3]);
        own = s3_cmd_reg.edge_sel ? s3_rot_reg : win_reg[4];
    end

    always_comb begin
        gain_x = {{(PROD_W-GAIN_W){gain[GAIN_W-1]}}, gain};
        sum_x  = {{(PROD_W-SUM_W){s4_sum_reg[SUM_W-1]}}, s4_sum_reg};
    end

    // floor and truncation agree once negatives clamp to zero
    always_comb begin
        t_full = {s5_prod_reg[PROD_W-1], s5_prod_reg}
               + {{(T_W-OFFSET_W-FRAC_W){offset[OFFSET_W-1]}}, offset, FRAC_W'(0)};
        if (t_full[T_W-1]) begin
            emb_pix = '0;
        end else if (|t_full[T_W-2:PIX_W+FRAC_W]) begin
            emb_pix = '1;
        end else begin
            emb_pix = t_full[PIX_W+FRAC_W-1:FRAC_W];
        end
        res.pix  = s5_cmd_reg.border ? s5_own_reg : emb_pix;
        res.last = s5_cmd_reg.last;
        res_push = s5_valid_reg && s5_cmd_reg.do_out;
    end

    always_ff @(posedge aclk) begin
        s2_cmd_reg  <= head_cmd;
        wr_addr_reg <= s2_cmd_reg.col;
        wr_pix_reg  <= s2_cmd_reg.pix;
        wr_b_reg    <= b_pix;
        if (s2_valid_reg) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= a_pix;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= b_pix;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s2_cmd_reg.pix;
        end
        s3_cmd_reg  <= s2_cmd_reg;
        s3_rot_reg  <= rot_pix;
        s4_cmd_reg  <= s3_cmd_reg;
        s4_sum_reg  <= sum;
        s4_own_reg  <= own;
        s5_cmd_reg  <= s4_cmd_reg;
        s5_prod_reg <= gain_x * sum_x;
        s5_own_reg  <= s4_own_reg;
        if (res_push) begin
            omem_reg[owr_ptr_reg] <= res;
        end
    end

    assign out_valid = ocount_reg != '0;
    assign out_item  = omem_reg[ord_ptr_reg];
    assign out_pop   = out_valid && out_ready;

    always_comb begin
        ocount_next = ocount_reg;
        if (res_push && !out_pop) begin
            ocount_next = ocount_reg + OCNT_W'(1);
        end else if (out_pop && !res_push) begin
            ocount_next = ocount_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            owr_ptr_reg  <= '0;
            ord_ptr_reg  <= '0;
            ocount_reg   <= '0;
        end else begin
            s2_valid_reg <= pop;
            wr_valid_reg <= s2_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            if (res_push) begin
                owr_ptr_reg <= owr_ptr_reg + OPTR_W'(1);
            end
            if (out_pop) begin
                ord_ptr_reg <= ord_ptr_reg + OPTR_W'(1);
            end
            ocount_reg <= ocount_next;
        end
    end

endmodule

### hw/rtl/emboss_filter_3x3.sv
// 3x3 emboss filter on an 8-bit grayscale raster stream. It takes one transfer per clock
// unless the command queue is full and returns at most one pixel per transfer: the result
// for raster position k leaves with the input transfer at position k + width + 1, so
// after a frame the last width + 1 results are drained by flush transfers (tuser[1]).
// Interior pixels get the kernel (-1 -1 0 / -1 0 1 / 0 1 1), scaled by the Q4.8 gain,
// biased by offset, clamped to 0..255; border pixels pass unchanged and m_tlast marks
// the bottom-right pixel. tuser[0] starts a frame. A front end counts positions and
// queues work; a back end reads and writes the two line stores once per pixel, runs sum,
// multiply and clamp in pipeline stages and holds results in an 8-entry output queue.
// Line stores need no clearing after reset.
// Registers: 0 gain, 1 offset, 2 frame width (3..4096), 3 frame height (3..4096);
// write them only while no result is outstanding.
module emboss_filter_3x3
    import emb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // pixel_in
    input  logic [1:0]            s_tuser,   // frame_start, flush
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // pixel_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [GAIN_W-1:0]   gain_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    geom_t                      geom_reg;
    logic [GEOM_W-1:0]          w_new;
    logic [ROW_W-1:0]           h_new;
    logic                       cfg_wr;

    logic q_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;
    out_t out_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        w_new = clamp_width(cfg_data);
        h_new = clamp_height(cfg_data);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= GAIN_W'(GAIN_RESET);
            offset_reg   <= OFFSET_W'(OFFSET_RESET);
            geom_reg.w   <= GEOM_W'(WIDTH_RESET);
            geom_reg.wm1 <= COL_W'(WIDTH_RESET - 1);
            geom_reg.h   <= ROW_W'(HEIGHT_RESET);
            geom_reg.hm1 <= ROW_W'(HEIGHT_RESET - 1);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_GAIN: begin
                    gain_reg <= cfg_data[GAIN_W-1:0];
                end
                REG_OFFSET: begin
                    offset_reg <= cfg_data[OFFSET_W-1:0];
                end
                REG_WIDTH: begin
                    geom_reg.w   <= w_new;
                    geom_reg.wm1 <= COL_W'(w_new - GEOM_W'(1));
                end
                REG_HEIGHT: begin
                    geom_reg.h   <= h_new;
                    geom_reg.hm1 <= h_new - ROW_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    emb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pixel (s_tdata),
        .in_start (s_tuser[0]),
        .in_flush (s_tuser[1]),
        .geom     (geom_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    emb_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    emb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .geom       (geom_reg),
        .gain       (gain_reg),
        .offset     (offset_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    assign m_tdata = out_item.pix;
    assign m_tlast = out_item.last;

endmodule

### hw/rtl/emb_checker.sv
module emb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with the sink draining, the input side recovers
    a_input_recovers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready ##1 m_tready ##1 m_tready |=> s_tready)
        else $error("input stalled while output drains");

    // configuration port never back-pressures
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind emboss_filter_3x3 emb_checker u_checker (.*);

### sim/emboss_filter_3x3_test.sv
module emboss_filter_3x3_test;
    import emb_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1150;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;    // pixel_in
    logic [1:0]            s_tuser   = '0;    // frame_start, flush
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // pixel_out
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of registers and filter state
    logic [GAIN_W-1:0]     gain_reg   = GAIN_W'(GAIN_RESET);
    logic [OFFSET_W-1:0]   offset_reg = OFFSET_W'(OFFSET_RESET);
    logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RESET);
    logic [PIX_W-1:0]      row_up     [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]      row_two_up [MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]      win        [WIN_N]     = '{default: '0};
    int                    in_col  = 0;
    int                    in_row  = 0;
    int                    out_col = 0;
    int                    out_row = 0;

    out_t pending_pixels [$];
    out_t next_pixel;

    int tx_idle_pct     = 13;
    int rx_idle_pct     = 13;
    int rx_hold_cycles  = 0;
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int frames_sent     = 0;

    emboss_filter_3x3 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int active_width();
        int v;
        v = int'(width_reg);
        if (v < MIN_DIM) begin
            v = MIN_DIM;
        end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
        end
        return v;
    endfunction

    function automatic int active_height();
        int v;
        v = int'(height_reg);
        if (v < MIN_DIM) begin
            v = MIN_DIM;
        end else if (v > MAX_HEIGHT) begin
            v = MAX_HEIGHT;
        end
        return v;
    endfunction

    function automatic bit frame_finished();
        int r;
        r = (out_col >= active_width()) ? out_row + 1 : out_row;
        return r >= active_height();
    endfunction

    // one accepted input transfer through the emboss pipeline model
    task automatic predict_transfer(input logic [7:0] pix_in, input logic start, input logic fl);
        int         w, h, idx, c, ksum, acc;
        logic [7:0] pix, right_edge, own, val;
        logic       border;
        out_t       res;
        w   = active_width();
        h   = active_height();
        pix = pix_in;
        if (start) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) return;
        idx = in_row * w + in_col;
        if (idx >= w * h) begin
            pix = '0;
        end else if (fl) begin
            return;
        end
        c          = in_col;
        right_edge = row_two_up[w-1];
        win[0] = win[1]; win[1] = win[2]; win[2] = row_two_up[c];
        win[3] = win[4]; win[4] = win[5]; win[5] = row_up[c];
        win[6] = win[7]; win[7] = win[8]; win[8] = pix;
        row_two_up[c] = row_up[c];
        row_up[c]     = pix;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (idx < w + 1) return;
        own    = (out_col == w - 1) ? right_edge : win[4];
        border = out_row == 0 || out_row == h - 1 || out_col == 0 || out_col == w - 1;
        if (border) begin
            val = own;
        end else begin
            ksum = -int'(win[0]) - int'(win[1]) - int'(win[3])
                   + int'(win[5]) + int'(win[7]) + int'(win[8]);
            acc  = int'($signed(gain_reg)) * ksum + int'($signed(offset_reg)) * 256;
            acc  = acc / 256;
            val  = (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 : 8'(acc);
        end
        res.pix  = val;
        res.last = out_row == h - 1 && out_col == w - 1;
        pending_pixels.push_back(res);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endtask

    task automatic send_item(input logic [7:0] pix, input logic start, input logic fl);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= {fl, start};
        do @(posedge aclk); while (!s_tready);
        predict_transfer(pix, start, fl);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input int gain, input int offset, input int width,
                                input int height);
        logic [CFG_IDX_W-1:0]  idx_list  [4];
        logic [CFG_DATA_W-1:0] data_list [4];
        idx_list  = '{REG_GAIN, REG_OFFSET, REG_WIDTH, REG_HEIGHT};
        data_list = '{CFG_DATA_W'(gain), CFG_DATA_W'(offset),
                      CFG_DATA_W'(width), CFG_DATA_W'(height)};
        for (int r = 0; r < 4; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[r];
            cfg_data  <= data_list[r];
            do @(posedge aclk); while (!cfg_ready);
            case (idx_list[r])
                REG_GAIN:   gain_reg   = data_list[r][GAIN_W-1:0];
                REG_OFFSET: offset_reg = data_list[r][OFFSET_W-1:0];
                REG_WIDTH:  width_reg  = data_list[r];
                REG_HEIGHT: height_reg = data_list[r];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_frame(input int flush_pct);
        while (!frame_finished())
            send_item(8'($urandom), 1'b0, $urandom_range(99) < flush_pct);
    endtask

    // full frame, optional dropped flushes inside it and a stray item after it
    task automatic send_frame(input int noise_pct, input bit binary_pixels);
        int n;
        n = active_width() * active_height();
        for (int p = 0; p < n; p++) begin
            if (p > 0 && $urandom_range(99) < noise_pct)
                send_item(8'($urandom), 1'b0, 1'b1);
            if (binary_pixels)
                send_item($urandom_range(1) ? 8'hFF : 8'h00, p == 0, 1'b0);
            else
                send_item(8'($urandom), p == 0, 1'b0);
        end
        drain_frame(75);
        if ($urandom_range(99) < noise_pct)
            send_item(8'($urandom), 1'b0, $urandom_range(1));
        frames_sent++;
    endtask

    task automatic test_corner_cases();
        logic [7:0] tile [9];
        tile = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h01};
        settle();
        program_regs(GAIN_RESET, OFFSET_RESET, 2, 1);   // clamps to 3x3
        send_item(8'h5A, 1'b1, 1'b1);                   // start on a flush
        for (int p = 0; p < 9; p++) begin
            if (p == 4) send_item(8'hC3, 1'b0, 1'b1);   // flush mid-frame, dropped
            send_item(tile[p], 1'b0, 1'b0);
        end
        send_item(8'hAA, 1'b0, 1'b0);                   // surplus pixel drains
        repeat (3) send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h7E, 1'b0, 1'b1);                   // frame done, ignored
        send_item(8'h81, 1'b0, 1'b0);
        frames_sent++;
    endtask

    task automatic test_gain_offset_extremes();
        int gains   [6];
        int offsets [6];
        gains   = '{-2048, 2047, -2048, 2047, 1, -256};
        offsets = '{-512, 511, 511, -512, 0, 255};
        for (int i = 0; i < 6; i++) begin
            settle();
            program_regs(gains[i], offsets[i], 4, 4);
            send_frame(0, i < 4);
        end
    endtask

    // clamped geometry: a tiny frame, then the top rows of a maximum-height frame
    task automatic test_geometry_extremes();
        settle();
        program_regs(GAIN_RESET, OFFSET_RESET, 0, 2);
        send_frame(0, 1'b0);
        settle();
        program_regs(-300, -20, 1, 8191);
        send_item(8'($urandom), 1'b1, 1'b0);
        repeat (150) send_item(8'($urandom), 1'b0, 1'b0);
        frames_sent++;
    endtask

    // width shrinks while a frame is partly sent: columns wrap into the next row
    task automatic test_geometry_change();
        settle();
        program_regs(200, 40, 8, 6);
        for (int p = 0; p < 20; p++)
            send_item(8'($urandom), p == 0, 1'b0);
        settle();
        program_regs(200, 40, 3, 6);
        drain_frame(0);
        frames_sent++;
    endtask

    task automatic test_stall_and_pause();
        settle();
        program_regs(-512, 300, 16, 8);
        rx_hold_cycles = 400;
        send_frame(0, 1'b0);
        wait_for_results();
        send_frame(5, 1'b0);
    endtask

    task automatic test_random_stream();
        int first_item, frame_no, g, o, w, h, n;
        first_item = items_sent;
        frame_no   = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (frame_no == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (frame_no == 12) begin
                tx_idle_pct = 13;
                rx_idle_pct = 13;
            end
            if (frame_no % 2 == 0) begin
                g = ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                             : int'($urandom_range(512)) - 128;
                o = ($urandom_range(3) == 0) ? int'($urandom_range(8191))
                                             : int'($urandom_range(256)) - 128;
                w = ($urandom_range(9) == 0) ? int'($urandom_range(2))
                                             : int'($urandom_range(20, 3));
                h = ($urandom_range(9) == 0) ? int'($urandom_range(2))
                                             : int'($urandom_range(10, 3));
                settle();
                program_regs(g, o, w, h);
            end
            case ($urandom_range(9))
                0: begin
                    // aborted by the next frame start
                    n = active_width() * active_height();
                    send_item(8'($urandom), 1'b1, 1'b0);
                    repeat ($urandom_range(n - 2)) send_item(8'($urandom), 1'b0, 1'b0);
                end
                1:       send_frame(30, 1'b0);
                2:       send_frame(5, 1'b1);
                default: send_frame($urandom_range(1) ? 0 : 5, 1'b0);
            endcase
            frame_no++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $error("unexpected transfer: pixel_out %0d frame_last %0b",
                           m_tdata, m_tlast);
                    error_count++;
                end else begin
                    next_pixel = pending_pixels.pop_front();
                    if (m_tdata !== next_pixel.pix) begin
                        $error("pixel_out: expected %0d, actual %0d", next_pixel.pix, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== next_pixel.last) begin
                        $error("frame_last: expected %0b, actual %0b", next_pixel.last, m_tlast);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_cases();
        test_gain_offset_extremes();
        test_geometry_extremes();
        test_geometry_change();
        test_stall_and_pause();
        test_random_stream();
        settle();
        $display("%0d input and %0d output transfers over %0d frames",
                 items_sent, results_checked, frames_sent);
        $display("frames from 3x3 to 20x10 plus a clamped 3x4096 start, full gain/offset range, stalls and aborts");
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/emb_pkg.sv
hw/rtl/emb_ram.sv
hw/rtl/emb_front.sv
hw/rtl/emb_cmd_queue.sv
hw/rtl/emb_back.sv
hw/rtl/emboss_filter_3x3.sv
hw/rtl/emb_checker.sv
sim/emboss_filter_3x3_test.sv
